// ===== hw/rtl/dsfw_pkg.sv =====
`default_nettype none

package dsfw_pkg;

  // default frame length in bits
  localparam int FRAME_BITS_DEF = 16;

  // input item width of the command word before fitting to the frame
  localparam int CMD_BITS = 16;

  // operation codes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RAW   = 1'b1;

  // chip indexes
  localparam logic CHIP0 = 1'b0;
  localparam logic CHIP1 = 1'b1;

  // pin levels of one output item, lowest bit first: clock, data, select0_n, select1_n
  typedef struct packed {
    logic select1_n;
    logic select0_n;
    logic serial_data;
    logic serial_clock;
  } pins_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dsfw_front.sv =====
`default_nettype none

module dsfw_front #(
  parameter int FRAME_BITS = 16
) (
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [FRAME_BITS-1:0]      q_word,
  output logic                       q_chip
);
  import dsfw_pkg::*;

  logic [3:0]          channel;
  logic [11:0]         dac_code;
  logic [CMD_BITS-1:0] raw_word;
  logic                raw_chip;
  logic [CMD_BITS-1:0] cmd;
  logic [31:0]         cmd_ext;

  assign channel  = s_tdata[3:0];
  assign dac_code = s_tdata[15:4];
  assign raw_word = s_tdata[31:16];
  assign raw_chip = s_tdata[32];

  // classify the item and build the command word
  always_comb begin
    unique case (s_tuser)
      OP_WRITE: begin
        cmd    = {1'b0, channel[2:0], dac_code};
        q_chip = channel[3];
      end
      OP_RAW: begin
        cmd    = raw_word;
        q_chip = raw_chip;
      end
      default: begin
        cmd    = '0;
        q_chip = CHIP0;
      end
    endcase
  end

  // zero-extend, then keep the frame's low bits
  assign cmd_ext = {{(32 - CMD_BITS){1'b0}}, cmd};
  assign q_word  = cmd_ext[FRAME_BITS-1:0];

  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/dsfw_queue.sv =====
`default_nettype none

module dsfw_queue #(
  parameter int WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  // two-entry queue, head always in slot0
  logic [WIDTH-1:0] slot0;
  logic [WIDTH-1:0] slot1;
  logic [1:0]       count;
  logic             do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = slot0;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (push && count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dsfw_back.sv =====
`default_nettype none

module dsfw_back #(
  parameter int FRAME_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  edge_level,
  input  wire logic                  q_valid,
  input  wire logic [FRAME_BITS-1:0] q_word,
  input  wire logic                  q_chip,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,
  output logic                       m_tlast
);
  import dsfw_pkg::*;

  localparam int LAST_STEP = 2 * FRAME_BITS;
  localparam int CW        = $clog2(LAST_STEP + 1);

  logic                  busy;
  logic [CW-1:0]         step;
  logic [FRAME_BITS-1:0] shift;
  logic                  adv;
  logic                  at_release;
  pins_t                 pins;

  assign adv        = ~m_tvalid | m_tready;
  assign at_release = (step == CW'(LAST_STEP));
  assign q_pop      = adv & ~busy & q_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      busy     <= 1'b0;
      step     <= '0;
    end else if (adv) begin
      if (busy) begin
        m_tvalid <= 1'b1;
        if (at_release) begin
          busy <= 1'b0;
        end
        step <= step + CW'(1);
      end else if (q_valid) begin
        m_tvalid <= 1'b1;
        busy     <= 1'b1;
        step     <= '0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy) begin
        if (at_release) begin
          pins.select0_n   <= 1'b1;
          pins.select1_n   <= 1'b1;
          pins.serial_clock <= edge_level;
          m_tlast          <= 1'b1;
        end else begin
          pins.serial_data  <= shift[FRAME_BITS-1];
          pins.serial_clock <= step[0] ? edge_level : ~edge_level;
          m_tlast           <= 1'b0;
          if (step[0]) begin
            shift <= {shift[FRAME_BITS-2:0], 1'b0};
          end
        end
      end else if (q_valid) begin
        shift             <= q_word;
        pins.select0_n    <= (q_chip != CHIP0);
        pins.select1_n    <= (q_chip != CHIP1);
        pins.serial_clock <= edge_level;
        pins.serial_data  <= 1'b0;
        m_tlast           <= 1'b0;
      end
    end
  end

  assign m_tdata = {4'b0000, pins};

endmodule

`default_nettype wire

// ===== hw/rtl/dac_spi_frame_writer_unit.sv =====
`default_nettype none

// serial write engine for two dac chips on one shared clock and data line.
// each input item becomes one frame of 2*FRAME_BITS+2 output items (34 at the
// default): select asserted, two pin states per frame bit msb first (clock at
// the inverse edge level with the data, then at the edge level), then select
// released with tlast high. the back serializer emits one output item per
// cycle while m_tready allows; a two-entry queue lets the front keep
// accepting while a frame is being sent. cfg_wdata sets the clock level of
// the sampling edge (0 = falling edge); the user must see that it is written
// only while idle, as the block itself does not enforce this.
module dac_spi_frame_writer_unit #(
  parameter int FRAME_BITS = dsfw_pkg::FRAME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: sample edge level
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // channel[3:0], dac_code[15:4], raw_word[31:16], raw_chip[32]
  input  wire logic        s_tuser,  // operation: 0 channel write, 1 raw word
  // output items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // serial_clock[0], serial_data[1], select0_n[2], select1_n[3]
  output logic             m_tlast   // frame_end
);
  import dsfw_pkg::*;

  logic                  edge_level;
  logic                  q_full;
  logic                  q_push;
  logic [FRAME_BITS-1:0] f_word;
  logic                  f_chip;
  logic                  q_pop;
  logic                  q_valid;
  logic [FRAME_BITS:0]   q_head;

  // sampling edge level register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_level <= 1'b0;
    end else if (cfg_we) begin
      edge_level <= cfg_wdata;
    end
  end

  // front: decode the item into frame word and target chip
  dsfw_front #(
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (f_word),
    .q_chip   (f_chip)
  );

  // queue of decoded frames, chip in the top bit
  dsfw_queue #(
    .WIDTH (FRAME_BITS + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_chip, f_word}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // back: serializer with registered output
  dsfw_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .edge_level (edge_level),
    .q_valid    (q_valid),
    .q_word     (q_head[FRAME_BITS-1:0]),
    .q_chip     (q_head[FRAME_BITS]),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire
